### rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and round functions for the SHA-256 hasher
// Holds the initial hash words, the round constant table and the item type
// passed from the byte front end to the compression back end.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  typedef logic [31:0] word_t;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/core/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo: short item queue between the byte front end and the back end
// Decouples input acceptance from block compression.
// ----------------------------------------------------------------------------
module sha_fifo import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t               slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  // payload store
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end
  end

endmodule

### rtl/core/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: block buffer, padding sequencer and one-round-per-cycle SHA-256
// Takes one queued item at a time, fills the 64-byte block, pads at end of
// message and writes four digest beats into the output register.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_ready,
  input  item_t       item,
  output logic        item_take,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic        finishing;   // current compression is the last of the message
  logic        pad_again;   // length block still to come after this one
  logic        pad_pending; // message closed on a full block, pad byte not placed
  logic [5:0]  rnd;
  word_t       w [16];
  word_t       h [8];
  word_t       v [8];
  logic [1:0]  out_idx;
  logic        out_valid;

  word_t w_new, s0, s1, t1, t2, k_val;
  logic [63:0] bit_len;

  assign bit_len = {byte_count, 3'b000};
  assign k_val   = round_k(rnd);
  assign item_take = (state == S_IDLE) && item_ready;

  // message schedule and round datapath
  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1    = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
          + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_val + w[0];
    t2    = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
          + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // output beat register
  assign empty       = !out_valid;
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 2'd3);
  assign digest_word = {h[{out_idx, 1'b0}], h[{out_idx, 1'b1}]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      byte_count  <= '0;
      finishing   <= 1'b0;
      pad_again   <= 1'b0;
      pad_pending <= 1'b0;
      rnd         <= '0;
      out_idx     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else begin
      case (state)
        // take one item: store byte, pick next action
        S_IDLE: begin
          if (item_ready) begin
            if (item.byte_valid) begin
              w[fill[5:2]][8*(3-fill[1:0]) +: 8] <= item.data_byte;
              fill       <= fill + 1'b1;
              byte_count <= byte_count + 1'b1;
            end
            if (item.byte_valid && fill == 6'd63) begin
              state       <= S_ROUND;
              rnd         <= '0;
              finishing   <= 1'b0;
              pad_again   <= 1'b0;
              pad_pending <= item.end_of_message;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
            end else if (item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        // pad byte if not yet placed, zeros and, if it fits, the length; then start compression
        S_PAD: begin
          if (fill >= 6'd56) begin
            // no room for length: pad this block, length block follows
            for (int i = 0; i < 64; i++) begin
              if (6'(i) == fill) w[i/4][8*(3-i%4) +: 8] <= PadByte;
              else if (6'(i) > fill) w[i/4][8*(3-i%4) +: 8] <= 8'h00;
            end
            pad_again <= 1'b1;
            finishing <= 1'b0;
          end else begin
            for (int i = 0; i < 56; i++) begin
              if (6'(i) == fill && !pad_again) w[i/4][8*(3-i%4) +: 8] <= PadByte;
              else if (6'(i) > fill || (pad_again && 6'(i) == fill))
                w[i/4][8*(3-i%4) +: 8] <= 8'h00;
            end
            w[14]     <= bit_len[63:32];
            w[15]     <= bit_len[31:0];
            pad_again <= 1'b0;
            finishing <= 1'b1;
          end
          pad_pending <= 1'b0;
          fill  <= '0;
          rnd   <= '0;
          state <= S_ROUND;
          for (int i = 0; i < 8; i++) v[i] <= h[i];
        end
        // one round per cycle, schedule slides in a 16-word window
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd   <= rnd + 1'b1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        // fold into chaining words
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fill <= '0;
          if (finishing) begin
            state     <= S_OUT;
            out_idx   <= '0;
            out_valid <= 1'b1;
          end else if (pad_again || pad_pending) begin
            // length block, or full block ended the message (pad byte pending)
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        // four digest beats, then restart the message
        S_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 2'd3) begin
              out_valid  <= 1'b0;
              state      <= S_IDLE;
              byte_count <= '0;
              finishing  <= 1'b0;
              for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Input queue: push a beat of {data_byte, byte_valid, end_of_message} while
// full is low. A beat with byte_valid low is a marker only; with
// end_of_message high the message closes after the beat's byte.
// Output queue: four digest beats per message, word_index 0 (most
// significant) to 3, last_word on the fourth; pop while empty is low.
// A four-entry item queue sits in front of the core so input beats keep
// landing while the core compresses; a pushed beat is registered in the
// queue before the core can take it. The core takes bytes while idle;
// every 64th byte starts 64 rounds (one per cycle) and the fold. End of
// message adds a padding step and a compression for each closing block:
// one block when the length fits, two when it spills over. The digest
// beats follow at up to one per cycle. The core holds the digest until
// all four beats are popped and takes no new item meanwhile; a stalled
// reader therefore backs up the input queue. Reset (rst, synchronous)
// empties the queue, loads the initial hash words and clears the byte count.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  input  logic        push,
  output logic        full,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);

  item_t in_item;
  item_t q_item;
  logic  q_empty;
  logic  q_take;

  assign in_item = '{data_byte: data_byte, byte_valid: byte_valid,
                     end_of_message: end_of_message};

  // front: item queue
  sha_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(in_item), .full(full),
    .pop(q_take), .pop_item(q_item), .empty(q_empty)
  );

  // back: buffer, padding and compression
  sha_core u_core (
    .clk(clk), .rst(rst), .item_ready(!q_empty), .item(q_item),
    .item_take(q_take), .digest_word(digest_word), .word_index(word_index),
    .last_word(last_word), .empty(empty), .pop(pop)
  );

  // checks
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_word == (word_index == 2'd3)))
    else $error("last_word disagrees with word_index");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && word_index != 2'd3) |=> (!empty && word_index == $past(word_index) + 2'd1))
    else $error("digest beat order broken");
  a_no_take_out: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !q_take)
    else $error("core took an item while digest pending");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for sha256_stream_hasher
// Streams directed and random byte messages into the hasher, computes the
// expected SHA-256 digest words in a local model and checks every digest
// beat in order. Sender and receiver idle at random in the first two of
// three phases, and one long reader stall backs the input queue up.
// ----------------------------------------------------------------------------
module tb;
  import sha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic        push;
  logic        full;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  logic        empty;
  logic        pop;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst), .data_byte(data_byte), .byte_valid(byte_valid),
    .end_of_message(end_of_message), .push(push), .full(full),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .empty(empty), .pop(pop)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t        pending_beats[$];
  digest_beat_t digest_queue[$];
  int           errors = 0;
  int           send_idle_pct = 36;
  int           recv_idle_pct = 73;
  logic         hold = 1'b0;
  int           quiet_cycles = 0;

  // local hash state
  logic [31:0]  hash_h[8];
  logic [7:0]   blk[64];
  int           blk_fill;
  logic [60:0]  byte_count;

  // constant tables built once
  logic [31:0] k_tab[64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  logic [31:0] iv_tab[8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                             32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void fold_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function automatic void restart_hash();
    hash_h = iv_tab;
    blk_fill = 0;
    byte_count = '0;
  endfunction

  // advance the local hash by one accepted beat, queue digest words on close
  function automatic void hash_beat(item_t it);
    logic [63:0] bit_len;
    digest_beat_t db;
    if (it.byte_valid) begin
      blk[blk_fill] = it.data_byte;
      blk_fill++;
      byte_count++;
      if (blk_fill == 64) begin
        fold_block();
        blk_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    bit_len = {byte_count, 3'b000};
    blk[blk_fill] = PadByte;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin blk[blk_fill] = 8'h00; blk_fill++; end
      fold_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin blk[blk_fill] = 8'h00; blk_fill++; end
    for (int k = 0; k < 8; k++) blk[56+k] = bit_len[63-8*k -: 8];
    fold_block();
    for (int k = 0; k < 4; k++) begin
      db = '{word: {hash_h[2*k], hash_h[2*k+1]}, idx: 2'(k), last: (k == 3)};
      digest_queue.insert(digest_queue.size(), db);
    end
    restart_hash();
  endfunction

  function automatic void add_beat(logic [7:0] b, logic bv, logic eom);
    item_t it;
    it = '{data_byte: b, byte_valid: bv, end_of_message: eom};
    pending_beats.insert(pending_beats.size(), it);
  endfunction

  // message of n random bytes, optional stray markers, closed by a byte or marker
  function automatic void add_message(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) add_beat(8'($urandom), 1'b0, 1'b0);
      add_beat(8'($urandom), 1'b1, (i == n - 1) && $urandom_range(0, 1));
    end
    if (n == 0 || !pending_beats[$].end_of_message) add_beat(8'($urandom), 1'b0, 1'b1);
  endfunction

  // driver: head of pending_beats is on the pins until accepted
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        hash_beat('{data_byte: data_byte, byte_valid: byte_valid,
                    end_of_message: end_of_message});
        void'(pending_beats.pop_front());
      end
      if (!push || !full) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push <= 1'b1;
          {data_byte, byte_valid, end_of_message} <= pending_beats[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest beat %h idx %0d", $time, digest_word, word_index);
          errors++;
        end else begin
          want = digest_queue.pop_front();
          if (digest_word !== want.word)
            $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word);
          if (word_index !== want.idx)
            $display("%0t: word_index expected %0d actual %0d", $time, want.idx, word_index);
          if (last_word !== want.last)
            $display("%0t: last_word expected %0d actual %0d", $time, want.last, last_word);
          if (digest_word !== want.word || word_index !== want.idx || last_word !== want.last)
            errors++;
        end
      end
      if (hold) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  initial begin
    int mlen;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    data_byte = '0;
    byte_valid = 1'b0;
    end_of_message = 1'b0;
    restart_hash();
    for (int i = 0; i < 64; i++) blk[i] = '0;

    // directed: empty message, idle marker, byte extremes
    add_beat(8'h00, 1'b0, 1'b1);
    add_beat(8'h5a, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);
    add_beat(8'hff, 1'b1, 1'b1);
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1);
    add_beat(8'haa, 1'b1, 1'b0);
    add_beat(8'h55, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // random messages: lengths around block and padding edges
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 73; recv_idle_pct = 36; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      while (pending_beats.size() < 100) begin
        case ($urandom_range(0, 3))
          0: mlen = $urandom_range(54, 66);
          1: mlen = $urandom_range(118, 130);
          default: mlen = $urandom_range(0, 12);
        endcase
        if (mlen > 100 - pending_beats.size()) mlen = 100 - pending_beats.size();
        add_message(mlen);
      end
      // long reader stall, counted in its own process
      if (phase == 1) begin
        fork
          begin
            hold <= 1'b1;
            repeat (400) @(posedge clk);
            hold <= 1'b0;
          end
        join_none
      end
      while (pending_beats.size() != 0 || push) @(posedge clk);
    end
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[sha256_stream_hasher] OK");
    else $display("[sha256_stream_hasher] ERROR");
    $finish;
  end
endmodule

### sim.f
rtl/core/sha_pkg.sv
rtl/core/sha_fifo.sv
rtl/core/sha_core.sv
rtl/core/sha256_stream_hasher.sv
bench/tb.sv
